// ===== design/sws_pkg.sv =====
// Package for the sine sample generator: widths, CORDIC constants, atan table.
// No dependencies.
package sws_pkg;

    localparam int TimeWidth      = 32;
    localparam int AmpWidth       = 16;
    localparam int PhaseWidth     = 16;
    localparam int CfgIndexWidth  = 2;
    localparam int CfgDataWidth   = 32;
    localparam int AtanEntries    = 24;

    localparam logic [CfgIndexWidth-1:0] RegAmplitude = 2'd0;
    localparam logic [CfgIndexWidth-1:0] RegPeriod    = 2'd1;
    localparam logic [CfgIndexWidth-1:0] RegPhase     = 2'd2;

    localparam logic [31:0] TurnPerRadQ32 = 32'd683565276;
    localparam logic signed [33:0] CordicGainQ30 = 34'sd652032874;

    // atan(2^-i) in 32-bit turn units
    function automatic logic signed [33:0] atan_turns(input int i);
        logic signed [33:0] v;
        begin
            case (i)
                0:  v = 34'sd536870912;
                1:  v = 34'sd316933405;
                2:  v = 34'sd167458907;
                3:  v = 34'sd85004756;
                4:  v = 34'sd42667331;
                5:  v = 34'sd21354465;
                6:  v = 34'sd10679838;
                7:  v = 34'sd5340245;
                8:  v = 34'sd2670163;
                9:  v = 34'sd1335086;
                10: v = 34'sd667544;
                11: v = 34'sd333772;
                12: v = 34'sd166886;
                13: v = 34'sd83443;
                14: v = 34'sd41721;
                15: v = 34'sd20860;
                16: v = 34'sd10430;
                17: v = 34'sd5215;
                18: v = 34'sd2607;
                19: v = 34'sd1303;
                20: v = 34'sd651;
                21: v = 34'sd325;
                22: v = 34'sd162;
                23: v = 34'sd81;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ===== design/sws_divider.sv =====
// Pipelined restoring divider: quotient and remainder, one bit per stage.
// Depends on nothing; carries a tag and a valid bit with each item.
module sws_divider #(
    parameter int NumWidth = 32,
    parameter int DenWidth = 32,
    parameter int TagWidth = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NumWidth-1:0] in_num,
    input  logic [DenWidth-1:0] in_rem,     // starting remainder, must be below in_den
    input  logic [DenWidth-1:0] in_den,
    input  logic [TagWidth-1:0] in_tag,
    output logic                out_valid,
    output logic [NumWidth-1:0] out_quot,
    output logic [DenWidth-1:0] out_rem,
    output logic [DenWidth-1:0] out_den,
    output logic [TagWidth-1:0] out_tag
);

    logic                valid_reg [NumWidth+1];
    logic [NumWidth-1:0] num_reg   [NumWidth+1];
    logic [DenWidth-1:0] rem_reg   [NumWidth+1];
    logic [DenWidth-1:0] den_reg   [NumWidth+1];
    logic [TagWidth-1:0] tag_reg   [NumWidth+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        num_reg[0]   = in_num;
        rem_reg[0]   = in_rem;
        den_reg[0]   = in_den;
        tag_reg[0]   = in_tag;
    end

    // one quotient bit per stage; num shifts out its MSB, quotient bits shift in
    for (genvar s = 0; s < NumWidth; s++)
    begin : g_stage
        logic [DenWidth:0]   trial;
        logic [DenWidth:0]   diff;
        logic [DenWidth-1:0] rem_next;
        logic [NumWidth-1:0] num_next;

        always_comb
        begin
            trial = {rem_reg[s], num_reg[s][NumWidth-1]};
            diff  = trial - {1'b0, den_reg[s]};
            if (!diff[DenWidth])
            begin
                rem_next = diff[DenWidth-1:0];
                num_next = {num_reg[s][NumWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DenWidth-1:0];
                num_next = {num_reg[s][NumWidth-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s+1] <= 1'b0;
            else if (en)
                valid_reg[s+1] <= valid_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s+1] <= num_next;
                rem_reg[s+1] <= rem_next;
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[NumWidth];
    assign out_quot  = num_reg[NumWidth];
    assign out_rem   = rem_reg[NumWidth];
    assign out_den   = den_reg[NumWidth];
    assign out_tag   = tag_reg[NumWidth];

endmodule

// ===== design/sws_cordic.sv =====
// Pipelined rotation-mode CORDIC, one micro-rotation per stage; y is sine in Q3.30.
// Depends on sws_pkg for the gain and atan table.
module sws_cordic
    import sws_pkg::*;
#(
    parameter int Steps    = 16,
    parameter int TagWidth = 17
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [33:0]  in_angle,
    input  logic [TagWidth-1:0] in_tag,
    output logic                out_valid,
    output logic signed [33:0]  out_sine,
    output logic [TagWidth-1:0] out_tag
);

    localparam int Stages = (Steps < AtanEntries) ? Steps : AtanEntries;

    logic                valid_reg [Stages+1];
    logic signed [33:0]  x_reg     [Stages+1];
    logic signed [33:0]  y_reg     [Stages+1];
    logic signed [33:0]  z_reg     [Stages+1];
    logic [TagWidth-1:0] tag_reg   [Stages+1];

    always_comb
    begin
        valid_reg[0] = in_valid;
        x_reg[0]     = CordicGainQ30;
        y_reg[0]     = '0;
        z_reg[0]     = in_angle;
        tag_reg[0]   = in_tag;
    end

    for (genvar i = 0; i < Stages; i++)
    begin : g_step
        logic signed [33:0] dx, dy, x_next, y_next, z_next;

        // rotate toward z = 0
        always_comb
        begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (!z_reg[i][33])
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - atan_turns(i);
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + atan_turns(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i+1] <= 1'b0;
            else if (en)
                valid_reg[i+1] <= valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                tag_reg[i+1] <= tag_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[Stages];
    assign out_sine  = y_reg[Stages];
    assign out_tag   = tag_reg[Stages];

endmodule

// ===== design/sine_wave_sample_top.sv =====
// Top level of the sine sample generator: config registers, phase conversion,
// divider and CORDIC pipelines, scaling, output skid stage. Uses sws_pkg.
// Path: the bit-per-stage dividers (t mod P, then the turn fraction), the angle fold
// register, the CORDIC stages, the product register and the output register.
// Throughput: one transfer per cycle; an output stall parks one result in a skid
// register, then freezes the whole pipeline. Reset: asynchronous, clears valid
// bits and config registers to zero.
module sine_wave_sample_top
    import sws_pkg::*;
#(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [31:0]              s_axis_tdata,   // [31:0] time_ticks
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata,   // [15:0] sample_value
    output logic                     m_axis_tuser,   // [0] period_error
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data
);

    localparam int Fb = FRACTION_BITS;

    logic signed [15:0] amplitude_reg;
    logic [31:0]        period_reg;
    logic signed [15:0] phase_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg <= '0;
            period_reg    <= '0;
            phase_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegAmplitude: amplitude_reg <= cfg_data[15:0];
                RegPeriod:    period_reg    <= cfg_data;
                RegPhase:     phase_reg     <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // phase in turns, Q0.Fb (user must hold phase constant while items flow, not enforced; computed off-path)
    logic [15:0]  ph_mag;
    logic [47:0]  ph_prod_reg;
    logic [Fb-1:0] ph_turns;
    logic [Fb-1:0] ph_turns_reg;
    logic [47:0]  ph_round;
    assign ph_mag = phase_reg[15] ? 16'(-phase_reg) : phase_reg;
    always_ff @(posedge clk)
    begin
        ph_prod_reg  <= 48'(ph_mag) * 48'(TurnPerRadQ32);
        ph_turns_reg <= ph_turns;
    end
    always_comb
    begin
        ph_round = (ph_prod_reg + (48'd1 << (44 - Fb))) >> (45 - Fb);
        ph_turns = phase_reg[15] ? Fb'(-ph_round) : ph_round[Fb-1:0];
    end

    // stall: the pipeline advances while the skid register is empty
    logic out_valid_reg;
    logic skid_valid_reg;
    logic en;
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // t mod P
    logic        d1_valid;
    logic [31:0] d1_quot, d1_rem, d1_den;
    logic        d1_tag;
    sws_divider #(.NumWidth(32), .DenWidth(32), .TagWidth(1)) u_mod (
        .clk, .rst_n, .en,
        .in_valid (s_axis_tvalid),
        .in_num   (s_axis_tdata),
        .in_rem   ('0),
        .in_den   (period_reg),
        .in_tag   (period_reg == '0),
        .out_valid(d1_valid),
        .out_quot (d1_quot),
        .out_rem  (d1_rem),
        .out_den  (d1_den),
        .out_tag  (d1_tag)
    );

    // remainder fraction: the long division continues from t mod P, giving (r*2^Fb)/P
    logic        d2_valid;
    logic [Fb-1:0] d2_quot;
    logic [31:0] d2_rem, d2_den;
    logic        d2_tag;
    sws_divider #(.NumWidth(Fb), .DenWidth(32), .TagWidth(1)) u_frac (
        .clk, .rst_n, .en,
        .in_valid (d1_valid),
        .in_num   ('0),
        .in_rem   (d1_rem),
        .in_den   (d1_den),
        .in_tag   (d1_tag),
        .out_valid(d2_valid),
        .out_quot (d2_quot),
        .out_rem  (d2_rem),
        .out_den  (d2_den),
        .out_tag  (d2_tag)
    );

    // angle fold stage
    logic               a_valid_reg;
    logic signed [33:0] a_angle_reg;
    logic               a_err_reg;
    logic [Fb-1:0]      ang_turn;
    logic [31:0]        ang32;
    logic signed [33:0] a_s, a_fold;
    always_comb
    begin
        ang_turn = d2_quot + ph_turns_reg;
        ang32    = 32'(ang_turn) << (32 - Fb);
        a_s      = 34'(signed'(ang32));
        if (a_s > 34'sd1073741824)
            a_fold = 34'sd2147483648 - a_s;
        else if (a_s < -34'sd1073741824)
            a_fold = -34'sd2147483648 - a_s;
        else
            a_fold = a_s;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= d2_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_angle_reg <= a_fold;
            a_err_reg   <= d2_tag;
        end
    end

    logic               c_valid;
    logic signed [33:0] c_sine;
    logic               c_err;
    sws_cordic #(.Steps(CORDIC_STEPS), .TagWidth(1)) u_cordic (
        .clk, .rst_n, .en,
        .in_valid (a_valid_reg),
        .in_angle (a_angle_reg),
        .in_tag   (a_err_reg),
        .out_valid(c_valid),
        .out_sine (c_sine),
        .out_tag  (c_err)
    );

    // amplitude product, then round and saturate (sample forced to zero on a period error)
    logic               p_valid_reg;
    logic signed [49:0] p_prod_reg;
    logic               p_err_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= c_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_prod_reg <= 50'(amplitude_reg) * 50'(c_sine);
            p_err_reg  <= c_err;
        end
    end

    logic signed [49:0] s_full;
    logic signed [15:0] s_sat;
    always_comb
    begin
        s_full = (p_prod_reg + 50'sd536870912) >>> 30;
        if (p_err_reg)
            s_sat = '0;
        else if (s_full > 50'sd32767)
            s_sat = 16'sh7FFF;
        else if (s_full < -50'sd32768)
            s_sat = 16'sh8000;
        else
            s_sat = s_full[15:0];
    end

    // output register with skid register; the skid entry is older than the pipeline
    logic [15:0] out_data_reg;
    logic        out_err_reg;
    logic [15:0] skid_data_reg;
    logic        skid_err_reg;
    logic        out_free;
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= p_valid_reg;
        end
        else if (en && p_valid_reg)
            skid_valid_reg <= 1'b1;
    end
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_err_reg  <= skid_err_reg;
            end
            else
            begin
                out_data_reg <= s_sat;
                out_err_reg  <= p_err_reg;
            end
        end
        else if (en)
        begin
            skid_data_reg <= s_sat;
            skid_err_reg  <= p_err_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_err_reg;

    logic unused_ok;
    assign unused_ok = ^{d1_quot, d2_rem, d2_den};

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("error sample not zero");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("stalled while output empty");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for sine_wave_sample_top: a self-checking stream test with its own
// sample predictor (modulo, turn fraction, phase, CORDIC, scaling). Uses sws_pkg.
module testbench;
    import sws_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int Steps    = 16;
    localparam int FracBits = 24;
    localparam int StallLimit = 4000;
    localparam int DrainCycles = 120;

    // atan(2^-i) in 32-bit turn units
    localparam longint AtanTurn [0:23] = '{
        536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335086, 667544, 333772,
        166886, 83443, 41721, 20860, 10430, 5215,
        2607, 1303, 651, 325, 162, 81
    };

    typedef struct packed {
        logic signed [15:0] sample;
        logic               period_error;
    } sample_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [31:0]              s_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [15:0]              m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    // shadow of the block's registers
    logic signed [15:0] amp_reg;
    logic [31:0]        period_reg;
    logic signed [15:0] phase_reg;

    sample_t expected_samples[$];
    int      mismatch_count;
    int      idle_pct;
    int      stall_pct;
    int      quiet_cycles;

    sine_wave_sample_top #(
        .CORDIC_STEPS (Steps),
        .FRACTION_BITS(FracBits)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // expected sample for one time value under the current register values
    function automatic sample_t predict_sample(input logic [31:0] t);
        logic [63:0] rem_ticks;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] ph;
        logic [63:0] ang;
        longint      a;
        longint      x;
        longint      y;
        longint      dx;
        longint      dy;
        longint      prod;
        longint      s;
        sample_t     res;
        if (period_reg == 0)
        begin
            res.sample = '0;
            res.period_error = 1'b1;
            return res;
        end
        rem_ticks = 64'(t) % 64'(period_reg);
        frac = (rem_ticks << FracBits) / 64'(period_reg);
        mag = (phase_reg < 0) ? 64'(-longint'(phase_reg)) : 64'(phase_reg);
        ph = (mag * 64'(TurnPerRadQ32) + (64'd1 << (44 - FracBits))) >> (45 - FracBits);
        if (phase_reg < 0)
            ph = 64'd0 - ph;
        ang = (frac + ph) & ((64'd1 << FracBits) - 1);
        ang = (ang << (32 - FracBits)) & 64'hFFFF_FFFF;
        a = ang[31] ? longint'(ang) - 64'sh1_0000_0000 : longint'(ang);
        // fold into [-1/4, +1/4] turn
        if (a > (64'sd1 <<< 30))
            a = (64'sd1 <<< 31) - a;
        else if (a < -(64'sd1 <<< 30))
            a = -(64'sd1 <<< 31) - a;
        // rotation-mode CORDIC
        x = longint'(CordicGainQ30);
        y = 0;
        for (int i = 0; i < Steps && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x = x - dx;
                y = y + dy;
                a = a - AtanTurn[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                a = a + AtanTurn[i];
            end
        end
        prod = longint'(amp_reg) * y;
        s = (prod + (64'sd1 <<< 29)) >>> 30;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        res.sample = 16'(s);
        res.period_error = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // register write; stops sending and waits until nothing is in flight
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
        s_axis_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            RegAmplitude: amp_reg = val[15:0];
            RegPeriod:    period_reg = val;
            RegPhase:     phase_reg = val[15:0];
            default:      ;
        endcase
    endtask

    // send one time value; tvalid stays high into the next call
    task automatic send_time(input logic [31:0] t);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_samples.push_back(predict_sample(t));
        @(negedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (expected_samples.size() == 0);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // random stall on the result side
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // result check and watchdog
    always @(posedge clk)
    begin
        sample_t got;
        sample_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sample = m_axis_tdata;
                got.period_error = m_axis_tuser;
                if (expected_samples.size() == 0)
                    report_mismatch("sample transfer with none expected");
                else
                begin
                    want = expected_samples.pop_front();
                    if (got.sample !== want.sample)
                        report_mismatch($sformatf("sample_value got %0d want %0d",
                                                  got.sample, want.sample));
                    if (got.period_error !== want.period_error)
                        report_mismatch($sformatf("period_error got %0b want %0b",
                                                  got.period_error, want.period_error));
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else if (s_axis_tvalid || expected_samples.size() != 0)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // zero period straight after reset: error flag, sample 0
    task automatic test_zero_period();
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        write_reg(RegAmplitude, 32'h0000_7FFF);
        send_time(32'h1234_5678);
        drain();
    endtask

    // field extremes, half and quarter turns, phase extremes, unused index
    task automatic test_directed();
        write_reg(RegPeriod, 32'd1);
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        write_reg(RegPeriod, 32'd1000);
        send_time(32'd250);
        send_time(32'd500);
        send_time(32'd750);
        send_time(32'd1999);
        drain();
        write_reg(RegAmplitude, 32'h0000_8000);
        write_reg(RegPeriod, 32'hFFFF_FFFF);
        send_time(32'h4000_0000);
        send_time(32'h7FFF_FFFF);
        send_time(32'hFFFF_FFFE);
        send_time(32'hFFFF_FFFF);
        drain();
        write_reg(RegPhase, 32'h0000_7FFF);
        write_reg(RegPeriod, 32'd4);
        send_time(32'd0);
        send_time(32'd1);
        drain();
        write_reg(RegPhase, 32'hFFFF_8000);
        send_time(32'd2);
        send_time(32'd3);
        drain();
        // writes to the unused index change nothing
        write_reg(2'd3, 32'hFFFF_FFFF);
        write_reg(RegAmplitude, 32'd0);
        send_time(32'd1);
        write_reg(RegAmplitude, 32'h0000_7FFF);
        write_reg(RegPhase, 32'd0);
        drain();
    endtask

    task automatic randomize_regs();
        logic [31:0] v;
        case ($urandom_range(3))
            0:       v = {$urandom_range(1) ? 16'hFFFF : 16'h0000,
                          $urandom_range(1) ? 16'h8000 : 16'h7FFF};
            default: v = $urandom;
        endcase
        write_reg(RegAmplitude, v);
        case ($urandom_range(5))
            0:       v = 32'hFFFF_FFFF;
            1:       v = $urandom_range(1, 16);
            2:       v = $urandom_range(1, 100000);
            3:       v = 32'd0;
            default: v = $urandom;
        endcase
        write_reg(RegPeriod, v);
        case ($urandom_range(3))
            0:       v = $urandom_range(1) ? 32'hFFFF_8000 : 32'h0000_7FFF;
            default: v = $urandom;
        endcase
        write_reg(RegPhase, v);
    endtask

    // random time values over several register settings and idle mixes
    task automatic test_random(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < 4; k++)
        begin
            randomize_regs();
            for (int n = 0; n < count / 4; n++)
                send_time($urandom_range(3) == 0 ? 32'(n * ($urandom_range(1, 8)))
                                                  : 32'($urandom));
            drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        amp_reg       = '0;
        period_reg    = '0;
        phase_reg     = '0;
        mismatch_count = 0;
        quiet_cycles  = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_period();
        test_directed();
        test_random(0, 0, 480);
        test_random(58, 0, 460);
        test_random(0, 58, 460);
        test_random(21, 21, 440);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
